// File: src/ibs_pkg.sv
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared constants and types for the IoU box suppression block.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int MAX_KEPT   = 64;
  localparam int SLOT_W     = $clog2(MAX_KEPT);
  localparam int COUNT_W    = $clog2(MAX_KEPT + 1);
  localparam int OUT_SLOT_W = 6;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 15;
  localparam int BOX_W      = 2 * COORD_W + 2 * SIZE_W;
  localparam int IN_DATA_W  = ((BOX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;
  localparam int THR_W      = 16;
  localparam int AREA_W     = 2 * SIZE_W;
  localparam int UNI_W      = AREA_W + 1;
  localparam int PROD_W     = THR_W + UNI_W;

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic [SIZE_W-1:0]         h;
    logic [SIZE_W-1:0]         w;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } box_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic busy;
  } iou_res_t;

endpackage

// File: src/ibs_ram.sv
// ----------------------------------------------------------------------------
// ibs_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ibs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/ibs_iou.sv
// ----------------------------------------------------------------------------
// ibs_iou
// Four-stage pipeline that tests one kept box per cycle against the
// candidate box: inter * 65536 > threshold * union.
// ----------------------------------------------------------------------------
module ibs_iou (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      kept_valid,
  input  ibs_pkg::box_t             kept_box,
  input  ibs_pkg::box_t             cand,
  input  logic [ibs_pkg::THR_W-1:0] thr,
  output ibs_pkg::iou_res_t         res
);

  logic signed [17:0] a_x, a_y, b_x, b_y;
  logic signed [17:0] a_xe, a_ye, b_xe, b_ye;
  logic signed [17:0] min_xe, min_ye, max_x, max_y;
  logic signed [17:0] iw, ih;
  logic               overlap;

  logic                              s1_v;
  logic [ibs_pkg::SIZE_W-1:0]        s1_iw, s1_ih, s1_bw, s1_bh, s1_aw, s1_ah;
  logic                              s2_v;
  logic [ibs_pkg::AREA_W-1:0]        s2_inter, s2_area_a, s2_area_b;
  logic                              s3_v;
  logic [ibs_pkg::AREA_W-1:0]        s3_inter;
  logic [ibs_pkg::UNI_W-1:0]         s3_uni;
  logic                              s4_v;
  logic [ibs_pkg::AREA_W-1:0]        s4_inter;
  logic [ibs_pkg::PROD_W-1:0]        s4_prod;

  always_comb begin
    a_x    = {{2{cand.x[15]}}, cand.x};
    a_y    = {{2{cand.y[15]}}, cand.y};
    b_x    = {{2{kept_box.x[15]}}, kept_box.x};
    b_y    = {{2{kept_box.y[15]}}, kept_box.y};
    a_xe   = a_x + $signed({3'b000, cand.w});
    a_ye   = a_y + $signed({3'b000, cand.h});
    b_xe   = b_x + $signed({3'b000, kept_box.w});
    b_ye   = b_y + $signed({3'b000, kept_box.h});
    min_xe = (a_xe < b_xe) ? a_xe : b_xe;
    min_ye = (a_ye < b_ye) ? a_ye : b_ye;
    max_x  = (a_x > b_x) ? a_x : b_x;
    max_y  = (a_y > b_y) ? a_y : b_y;
    iw     = min_xe - max_x;
    ih     = min_ye - max_y;
    overlap = !iw[17] && (|iw) && !ih[17] && (|ih);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= kept_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    s1_iw     <= overlap ? iw[ibs_pkg::SIZE_W-1:0] : '0;
    s1_ih     <= overlap ? ih[ibs_pkg::SIZE_W-1:0] : '0;
    s1_bw     <= kept_box.w;
    s1_bh     <= kept_box.h;
    s1_aw     <= cand.w;
    s1_ah     <= cand.h;
    s2_inter  <= s1_iw * s1_ih;
    s2_area_a <= s1_aw * s1_ah;
    s2_area_b <= s1_bw * s1_bh;
    s3_inter  <= s2_inter;
    s3_uni    <= {1'b0, s2_area_a} + {1'b0, s2_area_b} - {1'b0, s2_inter};
    s4_inter  <= s3_inter;
    s4_prod   <= {{ibs_pkg::UNI_W{1'b0}}, thr} * {{ibs_pkg::THR_W{1'b0}}, s3_uni};
  end

  assign res.valid = s4_v;
  assign res.hit   = {1'b0, s4_inter, 16'h0000} > s4_prod;
  assign res.busy  = kept_valid | s1_v | s2_v | s3_v | s4_v;

endmodule

// File: src/iou_box_suppression.sv
// ----------------------------------------------------------------------------
// iou_box_suppression
// Greedy non-maximum suppression over score-sorted boxes using IoU.
// ----------------------------------------------------------------------------
// Each box is checked against every kept box held in a single-port-read RAM,
// one kept box per cycle through a four-stage IoU pipeline, and is stored at
// the next free slot if none suppresses it and the table is not full. One
// item is handled at a time; the next one is accepted while a result still
// waits.
// ----------------------------------------------------------------------------
module iou_box_suppression (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // box_x, box_y, box_width, box_height, zero fill
  input  logic [ibs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // first_of_set
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // keep, kept_slot, table_full
  output logic [ibs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ibs_pkg::THR_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                        state;
  logic [ibs_pkg::THR_W-1:0]     thr;
  logic [ibs_pkg::COUNT_W-1:0]   count;
  logic [ibs_pkg::COUNT_W-1:0]   rd_idx;
  logic                          rd_valid;
  logic                          suppressed;
  ibs_pkg::box_t                 cand;
  ibs_pkg::box_t                 kept_box;
  ibs_pkg::iou_res_t             res;

  logic                          rd_en;
  logic                          out_free;
  logic                          store;
  logic                          full;
  logic                          finish;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign rd_en         = (state == ST_SCAN) && (rd_idx < count);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign full          = (count == ibs_pkg::COUNT_W'(ibs_pkg::MAX_KEPT));
  assign finish        = (state == ST_DONE) && out_free;
  assign store         = finish && !suppressed && !full;

  ibs_ram #(
    .WIDTH (ibs_pkg::BOX_W),
    .DEPTH (ibs_pkg::MAX_KEPT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count[ibs_pkg::SLOT_W-1:0]),
    .wr_data (cand),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[ibs_pkg::SLOT_W-1:0]),
    .rd_data (kept_box)
  );

  ibs_iou u_iou (
    .clk        (clk),
    .rst        (rst),
    .kept_valid (rd_valid),
    .kept_box   (kept_box),
    .cand       (cand),
    .thr        (thr),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      thr           <= ibs_pkg::THR_RESET;
      count         <= '0;
      rd_idx        <= '0;
      rd_valid      <= 1'b0;
      suppressed    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      rd_valid <= rd_en;
      if (res.valid && res.hit) begin
        suppressed <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cand       <= s_axis_tdata[ibs_pkg::BOX_W-1:0];
            rd_idx     <= '0;
            suppressed <= 1'b0;
            if (s_axis_tuser) begin
              count <= '0;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end else if (!rd_valid && !res.busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tvalid   <= 1'b1;
            m_axis_tdata[0] <= !suppressed && !full;
            m_axis_tdata[ibs_pkg::OUT_SLOT_W:1] <=
              (!suppressed && !full) ? ibs_pkg::OUT_SLOT_W'(count) : '0;
            m_axis_tdata[ibs_pkg::OUT_SLOT_W+1] <= !suppressed && full;
            if (store) begin
              count <= count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/ibs_checker.sv
// ----------------------------------------------------------------------------
// ibs_checker
// Port-level checks for the IoU box suppression block, bound to the top.
// ----------------------------------------------------------------------------
module ibs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ibs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // One item at a time: the input side closes after each accepted item.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on two consecutive cycles");

  // A box is either kept or dropped for lack of room, never both.
  a_keep_full_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[7]))
    else $error("keep and table_full both set");

  // A dropped box reports slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
    else $error("nonzero slot on a dropped box");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind iou_box_suppression ibs_checker u_ibs_checker (.*);
